FILE: rtl/core/necd_pkg.sv
// necd_pkg: shared types, register codes and constants of the nec ir edge decoder
// used by the interfaces and every module under rtl/core
package necd_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int DATA_BITS     = 32;
    localparam int REG_BITS      = 28;
    localparam int CFG_IDX_BITS  = 3;
    localparam int EDGE_BITS     = 7;
    localparam int BYTE_BITS     = 8;

    localparam logic [EDGE_BITS-1:0] LEADER_LOW_EDGE   = 7'd1;
    localparam logic [EDGE_BITS-1:0] LEADER_SPACE_EDGE = 7'd2;
    localparam logic [EDGE_BITS-1:0] FIRST_BIT_EDGE    = 7'd4;
    localparam logic [EDGE_BITS-1:0] LAST_BIT_EDGE     = EDGE_BITS'(2 * DATA_BITS + 2);
    localparam logic [EDGE_BITS-1:0] REPEAT_EDGES      = 7'd4;
    localparam logic [EDGE_BITS-1:0] FRAME_EDGES       = EDGE_BITS'(2 * DATA_BITS + 4);

    localparam logic [REG_BITS-1:0] LEADER_LOW_MIN_RST   = 28'd8000000;
    localparam logic [REG_BITS-1:0] LEADER_LOW_MAX_RST   = 28'd10000000;
    localparam logic [REG_BITS-1:0] KEY_SPACE_MIN_RST    = 28'd3500000;
    localparam logic [REG_BITS-1:0] KEY_SPACE_MAX_RST    = 28'd5500000;
    localparam logic [REG_BITS-1:0] REPEAT_SPACE_MIN_RST = 28'd2000000;
    localparam logic [REG_BITS-1:0] REPEAT_SPACE_MAX_RST = 28'd2500000;
    localparam logic [REG_BITS-1:0] ONE_SPACE_RST        = 28'd1000000;
    localparam logic [REG_BITS-1:0] IDLE_TIMEOUT_RST     = 28'd100000000;

    localparam logic [BYTE_BITS-1:0] ERR_BYTE = 8'hFF;
    localparam logic [BYTE_BITS-1:0] RPT_BYTE = 8'h00;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LEADER_LOW_MIN   = 3'd0,
        REG_LEADER_LOW_MAX   = 3'd1,
        REG_KEY_SPACE_MIN    = 3'd2,
        REG_KEY_SPACE_MAX    = 3'd3,
        REG_REPEAT_SPACE_MIN = 3'd4,
        REG_REPEAT_SPACE_MAX = 3'd5,
        REG_ONE_SPACE        = 3'd6,
        REG_IDLE_TIMEOUT     = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_KEY    = 2'd0,
        KIND_REPEAT = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic {
        CMD_EDGE = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [REG_BITS-1:0] leader_low_min;
        logic [REG_BITS-1:0] leader_low_max;
        logic [REG_BITS-1:0] key_space_min;
        logic [REG_BITS-1:0] key_space_max;
        logic [REG_BITS-1:0] repeat_space_min;
        logic [REG_BITS-1:0] repeat_space_max;
        logic [REG_BITS-1:0] one_space_threshold;
        logic [REG_BITS-1:0] idle_timeout;
    } cfg_t;

    typedef struct packed {
        logic                 valid;
        kind_t                kind;
        logic [BYTE_BITS-1:0] address;
        logic [BYTE_BITS-1:0] command;
    } result_t;

endpackage

FILE: rtl/core/necd_if.sv
// necd interfaces: event input, result output and register write channels
// depends on necd_pkg for field widths
interface necd_evt_if #(
    parameter int TIME_BITS = necd_pkg::TIME_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [TIME_BITS-1:0] time_ns;

    modport source (output valid, cmd, time_ns, input ready);
    modport sink (input valid, cmd, time_ns, output ready);
endinterface

interface necd_res_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     kind;
    logic [necd_pkg::BYTE_BITS-1:0] address;
    logic [necd_pkg::BYTE_BITS-1:0] command;

    modport source (output valid, kind, address, command, input ready);
    modport sink (input valid, kind, address, command, output ready);
endinterface

interface necd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [necd_pkg::CFG_IDX_BITS-1:0] index;
    logic [necd_pkg::REG_BITS-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/necd_regs.sv
// necd_regs: timing threshold registers written through the config channel
// depends on necd_pkg and necd_cfg_if
module necd_regs (
    input  logic              clk,
    input  logic              rst_n,
    necd_cfg_if.sink          cfg,
    output necd_pkg::cfg_t    regs
);

    necd_pkg::cfg_t regs_reg;
    necd_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (necd_pkg::reg_idx_t'(cfg.index))
                necd_pkg::REG_LEADER_LOW_MIN:   regs_next.leader_low_min      = cfg.data;
                necd_pkg::REG_LEADER_LOW_MAX:   regs_next.leader_low_max      = cfg.data;
                necd_pkg::REG_KEY_SPACE_MIN:    regs_next.key_space_min       = cfg.data;
                necd_pkg::REG_KEY_SPACE_MAX:    regs_next.key_space_max       = cfg.data;
                necd_pkg::REG_REPEAT_SPACE_MIN: regs_next.repeat_space_min    = cfg.data;
                necd_pkg::REG_REPEAT_SPACE_MAX: regs_next.repeat_space_max    = cfg.data;
                necd_pkg::REG_ONE_SPACE:        regs_next.one_space_threshold = cfg.data;
                necd_pkg::REG_IDLE_TIMEOUT:     regs_next.idle_timeout        = cfg.data;
                default:                        regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.leader_low_min      <= necd_pkg::LEADER_LOW_MIN_RST;
            regs_reg.leader_low_max      <= necd_pkg::LEADER_LOW_MAX_RST;
            regs_reg.key_space_min       <= necd_pkg::KEY_SPACE_MIN_RST;
            regs_reg.key_space_max       <= necd_pkg::KEY_SPACE_MAX_RST;
            regs_reg.repeat_space_min    <= necd_pkg::REPEAT_SPACE_MIN_RST;
            regs_reg.repeat_space_max    <= necd_pkg::REPEAT_SPACE_MAX_RST;
            regs_reg.one_space_threshold <= necd_pkg::ONE_SPACE_RST;
            regs_reg.idle_timeout        <= necd_pkg::IDLE_TIMEOUT_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

FILE: rtl/core/necd_frame.sv
// necd_frame: frame state (edge count, leader flags, bit shifter, idle timer)
// and the single-pass decision for one event; depends on necd_pkg
module necd_frame #(
    parameter int TIME_BITS = necd_pkg::TIME_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    go,
    input  logic                    cmd,
    input  logic [TIME_BITS-1:0]    time_ns,
    input  necd_pkg::cfg_t          regs,
    output necd_pkg::result_t       res
);

    logic [TIME_BITS-1:0]            last_time_reg, last_time_next;
    logic [necd_pkg::EDGE_BITS-1:0]  edge_cnt_reg, edge_cnt_next;
    logic                            lead_ok_reg, lead_ok_next;
    logic                            key_ok_reg, key_ok_next;
    logic                            rpt_ok_reg, rpt_ok_next;
    logic [necd_pkg::DATA_BITS-1:0]  shift_reg, shift_next;
    logic                            armed_reg, armed_next;

    logic [TIME_BITS-1:0]            delta;
    logic [necd_pkg::EDGE_BITS-1:0]  cnt_inc;
    logic                            bit_edge;
    logic [necd_pkg::BYTE_BITS-1:0]  b0, b1, b2, b3;

    // interval since last edge, modulo the time width
    assign delta   = time_ns - last_time_reg;
    assign cnt_inc = edge_cnt_reg + 1'b1;
    assign bit_edge = (edge_cnt_reg >= necd_pkg::FIRST_BIT_EDGE) &&
                      (edge_cnt_reg <= necd_pkg::LAST_BIT_EDGE) && !edge_cnt_reg[0];
    assign b0 = shift_reg[31:24];
    assign b1 = shift_reg[23:16];
    assign b2 = shift_reg[15:8];
    assign b3 = shift_reg[7:0];

    always_comb
    begin
        last_time_next = last_time_reg;
        edge_cnt_next  = edge_cnt_reg;
        lead_ok_next   = lead_ok_reg;
        key_ok_next    = key_ok_reg;
        rpt_ok_next    = rpt_ok_reg;
        shift_next     = shift_reg;
        armed_next     = armed_reg;
        res.valid      = 1'b0;
        res.kind       = necd_pkg::KIND_ERROR;
        res.address    = necd_pkg::ERR_BYTE;
        res.command    = necd_pkg::ERR_BYTE;

        if (necd_pkg::cmd_t'(cmd) == necd_pkg::CMD_TICK)
        begin
            if (armed_reg && (delta >= TIME_BITS'(regs.idle_timeout)))
            begin
                edge_cnt_next = '0;
                armed_next    = 1'b0;
                res.valid     = 1'b1;
            end
        end
        else
        begin
            if (edge_cnt_reg == necd_pkg::LEADER_LOW_EDGE)
            begin
                lead_ok_next = (delta >= TIME_BITS'(regs.leader_low_min)) &&
                               (delta <= TIME_BITS'(regs.leader_low_max));
            end
            else if (edge_cnt_reg == necd_pkg::LEADER_SPACE_EDGE)
            begin
                key_ok_next = (delta >= TIME_BITS'(regs.key_space_min)) &&
                              (delta <= TIME_BITS'(regs.key_space_max));
                rpt_ok_next = (delta >= TIME_BITS'(regs.repeat_space_min)) &&
                              (delta <= TIME_BITS'(regs.repeat_space_max));
            end
            else if (bit_edge)
            begin
                shift_next = {shift_reg[necd_pkg::DATA_BITS-2:0],
                              (delta > TIME_BITS'(regs.one_space_threshold))};
            end
            last_time_next = time_ns;
            edge_cnt_next  = cnt_inc;
            armed_next     = 1'b1;

            // flags used here were settled on earlier edges
            if ((cnt_inc == necd_pkg::REPEAT_EDGES) && lead_ok_reg && rpt_ok_reg)
            begin
                edge_cnt_next = '0;
                armed_next    = 1'b0;
                res.valid     = 1'b1;
                res.kind      = necd_pkg::KIND_REPEAT;
                res.address   = necd_pkg::RPT_BYTE;
                res.command   = necd_pkg::RPT_BYTE;
            end
            else if (cnt_inc >= necd_pkg::FRAME_EDGES)
            begin
                edge_cnt_next = '0;
                armed_next    = 1'b0;
                res.valid     = 1'b1;
                if (lead_ok_reg && key_ok_reg && (b0 == ~b1) && (b2 == ~b3))
                begin
                    res.kind    = necd_pkg::KIND_KEY;
                    res.address = b0;
                    res.command = b2;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            edge_cnt_reg  <= '0;
            lead_ok_reg   <= 1'b0;
            key_ok_reg    <= 1'b0;
            rpt_ok_reg    <= 1'b0;
            shift_reg     <= '0;
            armed_reg     <= 1'b0;
        end
        else if (go)
        begin
            last_time_reg <= last_time_next;
            edge_cnt_reg  <= edge_cnt_next;
            lead_ok_reg   <= lead_ok_next;
            key_ok_reg    <= key_ok_next;
            rpt_ok_reg    <= rpt_ok_next;
            shift_reg     <= shift_next;
            armed_reg     <= armed_next;
        end
    end

endmodule

FILE: rtl/core/nec_ir_edge_decoder.sv
// nec_ir_edge_decoder: top level, input register, frame stage and result register
// depends on necd_pkg, necd_if, necd_regs and necd_frame
//
// Decodes NEC infrared frames from timestamped receiver-pin edges and periodic
// time ticks. One event is taken every clock cycle when the result side keeps
// up: an event is held in the input register, is decoded in one pass against
// the frame state once the result register is free or being drained, and its
// result (if any) is loaded into the result register, where the sink takes it.
// The single frame-state update stage sets the rate; the input register is
// refilled in the same cycle it drains, and it holds while a result waits
// to be taken. An edge gives a repeat result on edge REPEAT_EDGES of a
// repeat frame, a key or error result on edge FRAME_EDGES of a key frame, and a
// tick gives an error once the idle timeout has run out since the last edge of
// an unfinished frame. Timing thresholds are eight 28-bit registers in ns,
// written through the config channel, which is always ready; a write takes
// effect on the next cycle and should only be made while the decoder is idle.
module nec_ir_edge_decoder #(
    parameter int TIME_BITS = necd_pkg::TIME_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    necd_evt_if.sink   evt,
    necd_res_if.source res,
    necd_cfg_if.sink   cfg
);

    // input register
    logic                 in_vld_reg, in_vld_next;
    logic                 in_cmd_reg;
    logic [TIME_BITS-1:0] in_time_reg;

    // result register
    logic                           out_vld_reg, out_vld_next;
    necd_pkg::kind_t                out_kind_reg;
    logic [necd_pkg::BYTE_BITS-1:0] out_addr_reg;
    logic [necd_pkg::BYTE_BITS-1:0] out_cmd_reg;

    necd_pkg::cfg_t    regs;
    necd_pkg::result_t frame_res;
    logic              advance;

    // the held event is decoded once the result slot is free or being drained
    assign advance   = in_vld_reg && (!out_vld_reg || res.ready);
    assign evt.ready = !in_vld_reg || advance;

    assign in_vld_next  = evt.valid ? 1'b1 : (in_vld_reg && !advance);
    assign out_vld_next = advance ? frame_res.valid : (out_vld_reg && !res.ready);

    necd_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    necd_frame #(
        .TIME_BITS (TIME_BITS)
    ) u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (advance),
        .cmd     (in_cmd_reg),
        .time_ns (in_time_reg),
        .regs    (regs),
        .res     (frame_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload: load event on transfer
    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            in_cmd_reg  <= evt.cmd;
            in_time_reg <= evt.time_ns;
        end
    end

    // payload: capture decoded result
    always_ff @(posedge clk)
    begin
        if (advance && frame_res.valid)
        begin
            out_kind_reg <= frame_res.kind;
            out_addr_reg <= frame_res.address;
            out_cmd_reg  <= frame_res.command;
        end
    end

    assign res.valid   = out_vld_reg;
    assign res.kind    = out_kind_reg;
    assign res.address = out_addr_reg;
    assign res.command = out_cmd_reg;

`ifndef ASSERT_OFF
    // error results always carry all-ones bytes
    a_err_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (out_kind_reg == necd_pkg::KIND_ERROR)) |->
        ((out_addr_reg == necd_pkg::ERR_BYTE) && (out_cmd_reg == necd_pkg::ERR_BYTE)))
        else $error("error result without all-ones bytes");

    // repeat results always carry zero bytes
    a_rpt_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (out_kind_reg == necd_pkg::KIND_REPEAT)) |->
        ((out_addr_reg == necd_pkg::RPT_BYTE) && (out_cmd_reg == necd_pkg::RPT_BYTE)))
        else $error("repeat result with nonzero bytes");

    // a held event that cannot advance is never dropped
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_time_reg)))
        else $error("stalled event lost from input register");

    // a pending result is not overwritten while the sink stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !res.ready) |-> !advance)
        else $error("result register overwritten while stalled");
`endif

endmodule
